FILE: rtl/rdsgt_pkg.sv
// Shared types, codes and helpers for the RDS group text decoder.
// No dependencies; imported by every module of the block.
package rdsgt_pkg;

   localparam int NameLen  = 8;
   localparam int TextLen  = 64;
   localparam int Lanes    = 4;
   localparam int TextRows = TextLen / Lanes;
   localparam int RowW     = $clog2(TextRows);
   localparam int IdxW     = $clog2(TextLen);
   localparam int LaneW    = $clog2(Lanes);
   localparam int NameIdxW = $clog2(NameLen);
   localparam int PtyW     = 5;

   localparam logic [7:0] CrCode     = 8'h0d;
   localparam logic [5:0] TextEndIdx = 6'd32;

   // Group type codes from block B bits 15..11
   localparam logic [4:0] GtName0A = 5'd0;
   localparam logic [4:0] GtName0B = 5'd1;
   localparam logic [4:0] GtText2A = 5'd4;
   localparam logic [4:0] GtText2B = 5'd5;

   typedef enum logic [1:0] {
      OP_GROUP     = 2'd0,
      OP_READ_NAME = 2'd1,
      OP_READ_TEXT = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef struct packed {
      logic             wr;
      logic             flag;
      logic [RowW-1:0]  row;
      logic [Lanes-1:0] lane_en;
      logic             clr_end;
   } txt_cmd_type;

   typedef struct packed {
      logic            en;
      logic [IdxW-1:0] idx;
   } txt_rd_type;

   function automatic logic [7:0] strip_cr(input logic [7:0] ch);
      return (ch == CrCode) ? 8'h00 : ch;
   endfunction

endpackage

FILE: rtl/rdsgt_text_mem.sv
// Radio text storage: two banks of byte-lane RAM, one row of four characters per word.
// Depends on rdsgt_pkg.
module rdsgt_text_mem (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic                                       wr_bank,
   input  logic [rdsgt_pkg::RowW-1:0]                 wr_row,
   input  logic [rdsgt_pkg::Lanes-1:0]                wr_lane_en,
   input  logic [rdsgt_pkg::Lanes*8-1:0]              wr_data,
   input  logic                                       rd_en,
   input  logic                                       rd_bank,
   input  logic [rdsgt_pkg::RowW-1:0]                 rd_row,
   output logic [rdsgt_pkg::Lanes*8-1:0]              rd_data_ff
);
   import rdsgt_pkg::*;

   localparam int Depth = 2 * TextRows;

   logic [RowW:0] wr_addr;
   logic [RowW:0] rd_addr;

   assign wr_addr = {wr_bank, wr_row};
   assign rd_addr = {rd_bank, rd_row};

   for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic [7:0] ram_ff [Depth];

      always_ff @(posedge clock) begin
         if (wr_en && wr_lane_en[l]) begin
            ram_ff[wr_addr] <= wr_data[l*8 +: 8];
         end
         if (rd_en) begin
            rd_data_ff[l*8 +: 8] <= ram_ff[rd_addr];
         end
      end
   end

endmodule

FILE: rtl/rdsgt_text_ctl.sv
// Text bank control: A/B flag, shown/work bank select and per-character valid bits.
// A swap flips the banks and invalidates the new work bank together, both registered. Depends on rdsgt_pkg.
module rdsgt_text_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  rdsgt_pkg::txt_cmd_type cmd,
   input  rdsgt_pkg::txt_rd_type  rd,
   output logic                   swap,
   output logic                   work_bank,
   output logic                   shown_bank_ff,
   output logic                   rd_valid_ff
);
   import rdsgt_pkg::*;

   logic                flag_ff;
   logic                flag_in;
   logic                shown_bank_in;
   logic [TextLen-1:0]  valid_ff [2];
   logic [TextLen-1:0]  work_valid_in;
   logic                rd_valid_in;

   assign swap      = cmd.wr && (cmd.flag != flag_ff);
   assign work_bank = swap ? shown_bank_ff : ~shown_bank_ff;

   always_comb begin
      flag_in       = swap ? cmd.flag : flag_ff;
      shown_bank_in = swap ? ~shown_bank_ff : shown_bank_ff;
      work_valid_in = swap ? '0 : valid_ff[work_bank];
      if (cmd.wr) begin
         for (int l = 0; l < Lanes; l++) begin
            if (cmd.lane_en[l]) begin
               work_valid_in[{cmd.row, LaneW'(l)}] = 1'b1;
            end
         end
      end
      // short text form ends the message at the middle of the buffer
      if (cmd.wr && cmd.clr_end) begin
         work_valid_in[TextEndIdx] = 1'b0;
      end
      rd_valid_in = valid_ff[shown_bank_ff][rd.idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff       <= 1'b0;
         shown_bank_ff <= 1'b0;
         valid_ff[0]   <= '0;
         valid_ff[1]   <= '0;
      end else begin
         flag_ff       <= flag_in;
         shown_bank_ff <= shown_bank_in;
         if (cmd.wr) begin
            valid_ff[work_bank] <= work_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_valid_ff <= rd_valid_in;
      end
   end

endmodule

FILE: rtl/rds_group_text_decoder.sv
// RDS group 0/2 text decoder, top level.
// Each accepted request beat gives a registered response beat, valid in the next cycle.
// One beat per cycle unless rsp_tready stalls; two-bank text RAM with one read and one write port.
// A flag change swaps banks in the same cycle; per-character valid bits make the new work bank empty.
// Reset (synchronous, active high) clears program type, station name, flag and all valid bits.
module rds_group_text_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] block_b, [31:16] block_c, [47:32] block_d, [53:48] read_index, [55:54] zero
   input  logic [55:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_char, [12:8] program_type, [13] text_swapped, [15:14] zero
   output logic [15:0] rsp_tdata
);
   import rdsgt_pkg::*;

   logic [15:0]         blk_b;
   logic [15:0]         blk_c;
   logic [15:0]         blk_d;
   logic [IdxW-1:0]     rd_idx;
   op_type              op;
   logic [4:0]          gtype;
   logic                accept;
   logic                name_wr;
   logic                is_2a;
   logic                is_2b;
   txt_cmd_type         cmd;
   txt_rd_type          rd;
   logic [Lanes*8-1:0]  wr_data;
   logic [7:0]          sc_hi, sc_lo, sd_hi, sd_lo;
   logic                swap;
   logic                work_bank;
   logic                shown_bank;
   logic                rd_valid_ff;
   logic [Lanes*8-1:0]  rd_data_ff;

   logic [7:0]          name_ff [NameLen];
   logic [PtyW-1:0]     pty_ff;
   logic [PtyW-1:0]     pty_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   op_type              rsp_op_ff;
   logic [7:0]          rsp_name_ff;
   logic [7:0]          rsp_name_in;
   logic [PtyW-1:0]     rsp_pty_ff;
   logic                rsp_swap_ff;
   logic [LaneW-1:0]    rsp_lane_ff;
   logic [7:0]          text_char;
   logic [7:0]          read_char;

   assign blk_b  = req_tdata[15:0];
   assign blk_c  = req_tdata[31:16];
   assign blk_d  = req_tdata[47:32];
   assign rd_idx = req_tdata[53:48];
   assign op     = op_type'(req_tuser);
   assign gtype  = blk_b[15:11];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign name_wr = accept && (op == OP_GROUP) && (gtype == GtName0A || gtype == GtName0B);
   assign is_2a   = (op == OP_GROUP) && (gtype == GtText2A);
   assign is_2b   = (op == OP_GROUP) && (gtype == GtText2B);

   assign sc_hi = strip_cr(blk_c[15:8]);
   assign sc_lo = strip_cr(blk_c[7:0]);
   assign sd_hi = strip_cr(blk_d[15:8]);
   assign sd_lo = strip_cr(blk_d[7:0]);

   always_comb begin
      cmd.wr      = accept && (is_2a || is_2b);
      cmd.flag    = blk_b[4];
      cmd.clr_end = is_2b;
      if (is_2a) begin
         cmd.row     = blk_b[3:0];
         cmd.lane_en = '1;
         wr_data     = {sd_lo, sd_hi, sc_lo, sc_hi};
      end else begin
         // two characters land in the low or high half of a row
         cmd.row     = {1'b0, blk_b[3:1]};
         cmd.lane_en = blk_b[0] ? 4'b1100 : 4'b0011;
         wr_data     = {sd_lo, sd_hi, sd_lo, sd_hi};
      end
      rd.en  = accept && (op == OP_READ_TEXT);
      rd.idx = rd_idx;
   end

   rdsgt_text_ctl u_ctl (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .rd            (rd),
      .swap          (swap),
      .work_bank     (work_bank),
      .shown_bank_ff (shown_bank),
      .rd_valid_ff   (rd_valid_ff)
   );

   rdsgt_text_mem u_mem (
      .clock      (clock),
      .wr_en      (cmd.wr),
      .wr_bank    (work_bank),
      .wr_row     (cmd.row),
      .wr_lane_en (cmd.lane_en),
      .wr_data    (wr_data),
      .rd_en      (rd.en),
      .rd_bank    (shown_bank),
      .rd_row     (rd_idx[IdxW-1:LaneW]),
      .rd_data_ff (rd_data_ff)
   );

   always_comb begin
      pty_in       = name_wr ? blk_b[9:5] : pty_ff;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
      rsp_name_in  = (rd_idx < IdxW'(NameLen)) ? name_ff[rd_idx[NameIdxW-1:0]] : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pty_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NameLen; i++) begin
            name_ff[i] <= 8'h00;
         end
      end else begin
         pty_ff       <= pty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (name_wr) begin
            name_ff[{blk_b[1:0], 1'b0}] <= blk_d[15:8];
            name_ff[{blk_b[1:0], 1'b1}] <= blk_d[7:0];
         end
      end
   end

   // hold the response payload while the beat waits
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_op_ff   <= op;
         rsp_name_ff <= rsp_name_in;
         rsp_pty_ff  <= pty_in;
         rsp_swap_ff <= swap;
         rsp_lane_ff <= rd_idx[LaneW-1:0];
      end
   end

   always_comb begin
      text_char = rd_valid_ff ? rd_data_ff[rsp_lane_ff*8 +: 8] : 8'h00;
      unique case (rsp_op_ff)
         OP_READ_NAME: read_char = rsp_name_ff;
         OP_READ_TEXT: read_char = text_char;
         default:      read_char = 8'h00;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_swap_ff, rsp_pty_ff, read_char};

   a_swap_flips_bank: assert property (@(posedge clock) disable iff (reset)
      swap |=> (shown_bank != $past(shown_bank)))
      else $error("text swap did not flip the shown bank");

   a_swap_only_group: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_swap_ff) |-> (rsp_op_ff == OP_GROUP && read_char == 8'h00))
      else $error("text swap reported on a read beat");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty response stage");

   a_no_swap_without_write: assert property (@(posedge clock) disable iff (reset)
      !cmd.wr |=> (shown_bank == $past(shown_bank)))
      else $error("shown bank changed without a text group");

endmodule
